>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> rtl/lrukv_pkg.sv
// Package for the LRU key-value cache with expiry: types, codes and constants.
// No dependencies.
package lrukv_pkg;

    localparam int DEF_CAPACITY   = 4;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    typedef enum logic [2:0] {
        FUNC_SET    = 3'd0,
        FUNC_GET    = 3'd1,
        FUNC_DEL    = 3'd2,
        FUNC_EXISTS = 3'd3,
        FUNC_EXPIRE = 3'd4,
        FUNC_TTL    = 3'd5,
        FUNC_TICK   = 3'd6
    } func_t;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NIL  = 3'd1;
    localparam logic [2:0] ST_VAL  = 3'd2;
    localparam logic [2:0] ST_FLAG = 3'd3;
    localparam logic [2:0] ST_TTL  = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        key;
        logic [31:0]        data_in;
        logic signed [31:0] seconds;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        data_out;
        logic signed [31:0] answer;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_DROP,
        S_EXEC,
        S_RANK,
        S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture command
        logic search;   // register match and victim search
        logic check;    // register expiry check of the hit
        logic drop;     // remove the hit (expired or deleted)
        logic exec;     // perform the command
        logic rank;     // apply the pending recency update
        logic respond;  // drive the result strobe
    } ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] func;
        logic       hit;
        logic       expired;
    } stat_t;

endpackage

>>> rtl/lrukv_ctrl.sv
// Controller for the LRU key-value cache: sequences one command at a time.
// Depends on lrukv_pkg.
module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t st,
    output ctrl_t ctl
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                ctl.search = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.check  = 1'b1;
                state_next = S_DROP;
            end
            S_DROP:
            begin
                // expired keys seen by get, exists, expire or ttl and delete hits
                // remove the entry
                if (st.hit && (st.func == FUNC_DEL
                    || (st.expired && (st.func == FUNC_GET || st.func == FUNC_EXISTS
                        || st.func == FUNC_EXPIRE || st.func == FUNC_TTL))))
                begin
                    ctl.drop = 1'b1;
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_RANK;
            end
            S_RANK:
            begin
                ctl.rank   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctl.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/lrukv_dp.sv
// Datapath for the LRU key-value cache: entry registers, search, ranks, clock.
// Depends on lrukv_pkg.
module lrukv_dp
    import lrukv_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  ctrl_t ctl,
    output stat_t st,
    output logic  strobe,
    output rsp_t  result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = IW;

    // Entry storage
    logic [CAPACITY-1:0]   valid_reg;
    logic [KEY_BITS-1:0]   key_reg   [CAPACITY];
    logic [VALUE_BITS-1:0] value_reg [CAPACITY];
    logic [CAPACITY-1:0]   hasexp_reg;
    logic [63:0]           exp_reg   [CAPACITY];
    logic [RW-1:0]         rank_reg  [CAPACITY];

    logic [63:0] now_reg;
    cmd_t        cmd_reg;
    logic        hit_reg, expired_reg, free_reg;
    logic [IW-1:0] slot_reg, free_slot_reg, lru_slot_reg;
    // pending rank update: mode 0 none, 1 make front, 2 drop, 3 insert
    logic [1:0]    rmode_reg;
    logic [IW-1:0] rslot_reg;
    logic [RW-1:0] rref_reg;
    logic          strobe_reg;
    rsp_t          result_reg;

    localparam logic [1:0] RM_NONE  = 2'd0;
    localparam logic [1:0] RM_FRONT = 2'd1;
    localparam logic [1:0] RM_DROP  = 2'd2;
    localparam logic [1:0] RM_INS   = 2'd3;

    logic [KEY_BITS-1:0]   key_w;
    logic [VALUE_BITS-1:0] val_w;
    assign key_w = KEY_BITS'(cmd_reg.key);
    assign val_w = VALUE_BITS'(cmd_reg.data_in);

    // Match, first free and LRU search (combinational, registered in SEARCH)
    logic          m_hit, m_free;
    logic [IW-1:0] m_slot, m_free_slot, m_lru_slot;
    logic [RW-1:0] m_best;
    always_comb
    begin
        m_hit = 1'b0; m_free = 1'b0;
        m_slot = '0; m_free_slot = '0; m_lru_slot = '0; m_best = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!m_hit && valid_reg[i] && key_reg[i] == key_w)
            begin
                m_hit  = 1'b1;
                m_slot = IW'(i);
            end
            if (!m_free && !valid_reg[i])
            begin
                m_free      = 1'b1;
                m_free_slot = IW'(i);
            end
            if (rank_reg[i] >= m_best)
            begin
                m_best     = rank_reg[i];
                m_lru_slot = IW'(i);
            end
        end
    end

    logic [63:0] diff_w;
    assign diff_w = exp_reg[slot_reg] - now_reg;
    logic [63:0] secs_w;
    assign secs_w = 64'(cmd_reg.seconds);

    assign st.func    = cmd_reg.func;
    assign st.hit     = hit_reg;
    assign st.expired = expired_reg;

    // Sequencing of the datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            now_reg    <= '0;
            strobe_reg <= 1'b0;
            rmode_reg  <= RM_NONE;
        end
        else
        begin
            strobe_reg <= ctl.respond;
            if (ctl.load)
            begin
                cmd_reg    <= cmd;
                result_reg <= '0;
                rmode_reg  <= RM_NONE;
            end
            if (ctl.search)
            begin
                hit_reg       <= m_hit;
                slot_reg      <= m_slot;
                free_reg      <= m_free;
                free_slot_reg <= m_free_slot;
                lru_slot_reg  <= m_lru_slot;
            end
            if (ctl.check)
            begin
                expired_reg <= hasexp_reg[slot_reg]
                               && (diff_w == '0 || diff_w[63]);
            end
            if (ctl.drop)
            begin
                valid_reg[slot_reg] <= 1'b0;
                rmode_reg           <= RM_DROP;
                rref_reg            <= rank_reg[slot_reg];
                if (cmd_reg.func != FUNC_DEL)
                begin
                    hit_reg <= 1'b0;
                end
            end
            if (ctl.exec)
            begin
                unique case (cmd_reg.func)
                    FUNC_SET:
                    begin
                        if (hit_reg)
                        begin
                            value_reg[slot_reg]  <= val_w;
                            hasexp_reg[slot_reg] <= 1'b0;
                            rmode_reg <= RM_FRONT;
                            rslot_reg <= slot_reg;
                            rref_reg  <= rank_reg[slot_reg];
                        end
                        else
                        begin
                            logic [IW-1:0] s;
                            s = free_reg ? free_slot_reg : lru_slot_reg;
                            valid_reg[s]  <= 1'b1;
                            key_reg[s]    <= key_w;
                            value_reg[s]  <= val_w;
                            hasexp_reg[s] <= 1'b0;
                            exp_reg[s]    <= '0;
                            rmode_reg     <= RM_INS;
                            rslot_reg     <= s;
                            // full store: victim rank drops out; others shift
                            rref_reg      <= free_reg ? '1 : rank_reg[s];
                        end
                    end
                    FUNC_GET:
                    begin
                        if (hit_reg)
                        begin
                            result_reg.status   <= ST_VAL;
                            result_reg.data_out <= 32'(value_reg[slot_reg]);
                            rmode_reg <= RM_FRONT;
                            rslot_reg <= slot_reg;
                            rref_reg  <= rank_reg[slot_reg];
                        end
                        else
                        begin
                            result_reg.status <= ST_NIL;
                        end
                    end
                    FUNC_DEL, FUNC_EXISTS:
                    begin
                        result_reg.status <= ST_FLAG;
                        result_reg.answer <= {31'd0, hit_reg};
                    end
                    FUNC_EXPIRE:
                    begin
                        result_reg.status <= ST_FLAG;
                        result_reg.answer <= {31'd0, hit_reg};
                        if (hit_reg)
                        begin
                            hasexp_reg[slot_reg] <= 1'b1;
                            exp_reg[slot_reg]    <= now_reg + secs_w;
                        end
                    end
                    FUNC_TTL:
                    begin
                        result_reg.status <= ST_TTL;
                        if (!hit_reg)
                            result_reg.answer <= -32'sd2;
                        else if (!hasexp_reg[slot_reg])
                            result_reg.answer <= -32'sd1;
                        else
                            result_reg.answer <= diff_w[31:0];
                    end
                    FUNC_TICK:
                    begin
                        now_reg <= now_reg + 64'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.rank)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    case (rmode_reg)
                        RM_FRONT:
                        begin
                            if (IW'(i) == rslot_reg)
                                rank_reg[i] <= '0;
                            else if (valid_reg[i] && rank_reg[i] < rref_reg)
                                rank_reg[i] <= rank_reg[i] + RW'(1);
                        end
                        RM_DROP:
                        begin
                            if (valid_reg[i] && rank_reg[i] > rref_reg)
                                rank_reg[i] <= rank_reg[i] - RW'(1);
                        end
                        RM_INS:
                        begin
                            if (IW'(i) == rslot_reg)
                                rank_reg[i] <= '0;
                            else if (valid_reg[i])
                            begin
                                // full: ranks above victim drop then all rise
                                if (rank_reg[i] <= rref_reg)
                                    rank_reg[i] <= rank_reg[i] + RW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

>>> rtl/lru_key_value_cache_with_expiry_top.sv
// From start to the result strobe the controller walks search, check, drop, execute
// and rank steps; a new command is taken only while busy is low.
// busy is high from the cycle after start until the result strobe cycle.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the store and clears the clock.
module lru_key_value_cache_with_expiry_top
    import lrukv_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic strobe,
    output rsp_t result
);

    ctrl_t ctl;
    stat_t st;

    lrukv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .ctl   (ctl)
    );

    lrukv_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .st     (st),
        .strobe (strobe),
        .result (result)
    );

endmodule

>>> rtl/lrukv_chk.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lrukv_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lrukv_chk
    import lrukv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input rsp_t result
);

    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `CHK_IMPL(a_strobe_busy, clk, rst_n, strobe, !busy)
    `CHK_NEXT(a_strobe_single, clk, rst_n, strobe, !strobe)
    `CHK_IMPL(a_status_range, clk, rst_n, strobe, result.status <= ST_TTL)
    `CHK_IMPL(a_data_hit, clk, rst_n, strobe && result.status != ST_VAL, result.data_out == '0)

endmodule

bind lru_key_value_cache_with_expiry_top lrukv_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

>>> sim/lrukv_checker.sv
// Checker for the LRU key-value cache: watches command and result transfers,
// predicts each result from its own store model and compares. Needs lrukv_pkg.
`timescale 1ns / 1ps
module lrukv_checker
    import lrukv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        strobe,
    input  rsp_t        result,
    output int          fail_count,
    output int          pending
);

    localparam int SLOTS = DEF_CAPACITY;

    // Shadow store
    logic [63:0] clock_now;
    logic        slot_used [SLOTS];
    logic [31:0] slot_key  [SLOTS];
    logic [31:0] slot_val  [SLOTS];
    logic        slot_ttl  [SLOTS];
    logic [63:0] slot_exp  [SLOTS];
    int          slot_rank [SLOTS];

    rsp_t expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    function automatic int lookup(logic [31:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void evict(int s);
        int r;
        r = slot_rank[s];
        slot_used[s] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_rank[i] > r)
                slot_rank[i]--;
    endfunction

    function automatic void promote(int s);
        int r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (i != s && slot_used[i] && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    // Lookup that drops a key whose expiry has passed
    function automatic int lookup_live(logic [31:0] k);
        int s;
        logic [63:0] d;
        s = lookup(k);
        if (s >= 0 && slot_ttl[s])
        begin
            d = slot_exp[s] - clock_now;
            if (d == 64'd0 || d[63])
            begin
                evict(s);
                return -1;
            end
        end
        return s;
    endfunction

    function automatic void insert(logic [31:0] k, logic [31:0] v);
        int s;
        int worst;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && s < 0)
                s = i;
        if (s < 0)
        begin
            worst = 0;
            s = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_rank[i] >= worst)
                begin
                    worst = slot_rank[i];
                    s = i;
                end
            evict(s);
        end
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
                slot_rank[i]++;
        slot_used[s] = 1'b1;
        slot_key[s]  = k;
        slot_val[s]  = v;
        slot_ttl[s]  = 1'b0;
        slot_exp[s]  = '0;
        slot_rank[s] = 0;
    endfunction

    function automatic rsp_t apply_command(cmd_t c);
        rsp_t r;
        int s;
        logic [63:0] secs;
        r = '0;
        secs = {{32{c.seconds[31]}}, c.seconds};
        case (c.func)
            FUNC_SET:
            begin
                s = lookup(c.key);
                if (s >= 0)
                begin
                    slot_val[s] = c.data_in;
                    slot_ttl[s] = 1'b0;
                    promote(s);
                end
                else
                    insert(c.key, c.data_in);
                r.status = ST_OK;
            end
            FUNC_GET:
            begin
                s = lookup_live(c.key);
                if (s < 0)
                    r.status = ST_NIL;
                else
                begin
                    promote(s);
                    r.status = ST_VAL;
                    r.data_out = slot_val[s];
                end
            end
            FUNC_DEL:
            begin
                s = lookup(c.key);
                r.status = ST_FLAG;
                if (s >= 0)
                begin
                    evict(s);
                    r.answer = 1;
                end
            end
            FUNC_EXISTS:
            begin
                r.status = ST_FLAG;
                r.answer = (lookup_live(c.key) >= 0) ? 1 : 0;
            end
            FUNC_EXPIRE:
            begin
                s = lookup_live(c.key);
                r.status = ST_FLAG;
                if (s >= 0)
                begin
                    slot_ttl[s] = 1'b1;
                    slot_exp[s] = clock_now + secs;
                    r.answer = 1;
                end
            end
            FUNC_TTL:
            begin
                s = lookup_live(c.key);
                r.status = ST_TTL;
                if (s < 0)
                    r.answer = -2;
                else if (!slot_ttl[s])
                    r.answer = -1;
                else
                    r.answer = 32'(slot_exp[s] - clock_now);
            end
            FUNC_TICK:
            begin
                clock_now++;
                r.status = ST_OK;
            end
            default: r.status = ST_OK;
        endcase
        return r;
    endfunction

    // Predict on each command transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            clock_now = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
            end
            expected_rsp_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result.status);
                        fail_count++;
                    end
                    if (result.data_out !== want.data_out)
                    begin
                        $display("%0t: data_out expected %h actual %h",
                                 $time, want.data_out, result.data_out);
                        fail_count++;
                    end
                    if (result.answer !== want.answer)
                    begin
                        $display("%0t: answer expected %0d actual %0d",
                                 $time, want.answer, result.answer);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_rsp_q = {expected_rsp_q, apply_command(cmd)};
        end
    end

endmodule

>>> sim/lru_key_value_cache_with_expiry_top_tb.sv
// Testbench top for the LRU key-value cache: drives directed and random commands
// with bursty gaps and gives the verdict. Needs lrukv_pkg and lrukv_checker.
`timescale 1ns / 1ps
module lru_key_value_cache_with_expiry_top_tb
    import lrukv_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy;
    logic strobe;
    rsp_t result;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   burst_left = 0;

    always #5 clk = ~clk;

    lru_key_value_cache_with_expiry_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .strobe(strobe), .result(result)
    );

    lrukv_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .strobe(strobe), .result(result), .fail_count(fail_count), .pending(pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Issue one command and wait for its transfer; gaps come in bursts
    task automatic issue(func_t f, logic [31:0] k, logic [31:0] v, logic [31:0] s);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= '{func: f, key: k, data_in: v, seconds: s};
        @(posedge clk);
        while (busy) @(posedge clk);
        // start is driven low before the next command is driven
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Keys drawn from a small pool so hits, evictions and expiry show up
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            default: return 32'(($urandom_range(0, 5) * 32'h1357_9BDF) ^ 32'h8000_0001);
        endcase
    endfunction

    function automatic logic [31:0] pick_seconds();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(-$urandom_range(0, 3));
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    initial
    begin
        func_t f;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, eviction, expiry cases, tick, unused code
        issue(FUNC_GET, 32'h0, 32'h0, 32'h0);
        issue(FUNC_TTL, 32'hFFFF_FFFF, 32'h0, 32'h0);
        issue(FUNC_SET, 32'h0, 32'hFFFF_FFFF, 32'h0);
        issue(FUNC_SET, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        issue(FUNC_SET, 32'h1, 32'h5, 32'h0);
        issue(FUNC_SET, 32'h2, 32'h6, 32'h0);
        issue(FUNC_GET, 32'h0, 32'h0, 32'h0);
        issue(FUNC_SET, 32'h3, 32'h7, 32'h0);
        issue(FUNC_EXISTS, 32'hFFFF_FFFF, 32'h0, 32'h0);
        issue(FUNC_EXPIRE, 32'h0, 32'h0, 32'h7FFF_FFFF);
        issue(FUNC_TTL, 32'h0, 32'h0, 32'h0);
        issue(FUNC_EXPIRE, 32'h1, 32'h0, 32'h8000_0000);
        issue(FUNC_SET, 32'h1, 32'h9, 32'h0);
        issue(FUNC_TTL, 32'h1, 32'h0, 32'h0);
        issue(FUNC_EXPIRE, 32'h2, 32'h0, 32'h0);
        issue(FUNC_DEL, 32'h2, 32'h0, 32'h0);
        issue(FUNC_EXPIRE, 32'h3, 32'h0, 32'h1);
        issue(FUNC_TICK, 32'h0, 32'h0, 32'h0);
        issue(FUNC_GET, 32'h3, 32'h0, 32'h0);
        issue(FUNC_DEL, 32'h3, 32'h0, 32'h0);
        issue(func_t'(3'd7), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(FUNC_GET, 32'h1, 32'h0, 32'h0);

        // Hold off until the store has answered everything
        while (pending != 0) @(posedge clk);

        // Random mix
        for (int n = 0; n < 500; n++)
        begin
            if (n == 250)
                while (pending != 0) @(posedge clk);
            f = func_t'($urandom_range(0, 9) > 7 ? $urandom_range(0, 7) : $urandom_range(0, 6));
            issue(f, pick_key(), $urandom(), pick_seconds());
        end

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lrukv_pkg.sv
rtl/lrukv_ctrl.sv
rtl/lrukv_dp.sv
rtl/lru_key_value_cache_with_expiry_top.sv
rtl/lrukv_chk.sv
sim/lrukv_checker.sv
sim/lru_key_value_cache_with_expiry_top_tb.sv
